@@ hw/rtl/twsp_pkg.sv @@
`timescale 1ns / 1ps

package twsp_pkg;

   localparam int WORD_W  = 64;
   localparam int OP_W    = 3;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = $clog2(WORD_W);
   localparam int ADDR_W  = 4;

   localparam logic [OP_W-1:0] OP_RAW    = 3'd0;
   localparam logic [OP_W-1:0] OP_URANGE = 3'd1;
   localparam logic [OP_W-1:0] OP_SRANGE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEED   = 3'd3;
   localparam logic [OP_W-1:0] OP_RESEED = 3'd4;

   localparam logic [KIND_W-1:0] KIND_RAW    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_URANGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SRANGE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] times5;
      logic [WORD_W-1:0] low_bound;
      logic [WORD_W-1:0] high_bound;
   } entry_type;

endpackage

@@ hw/rtl/two_word_starstar_prng.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_operation, req_low_bound, req_high_bound
// rsp       out        rsp_valid/rsp_stall  rsp_value, rsp_range_error
// csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A word that needs no remainder passes the queue and the back end's MIX, SETUP
// and DONE states before rsp_valid rises. A range draw with a nonzero valid span
// also goes through the one-bit-per-cycle remainder unit (DIV) and then FIX.
// The front end advances the generator words when it accepts a word, so up
// to two further words are taken while the back end is busy.
// Synchronous reset clears the words, seeds, queue pointers, FSM and rsp_valid.

module two_word_starstar_prng (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [twsp_pkg::OP_W-1:0]           req_operation,
   input  logic [twsp_pkg::WORD_W-1:0]         req_low_bound,
   input  logic [twsp_pkg::WORD_W-1:0]         req_high_bound,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [twsp_pkg::WORD_W-1:0]         rsp_value,
   output logic                                rsp_range_error,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [twsp_pkg::ADDR_W-1:0]         paddr,
   input  logic [twsp_pkg::WORD_W-1:0]         pwdata,
   output logic [twsp_pkg::WORD_W-1:0]         prdata,
   output logic                                pready
);

   logic [twsp_pkg::WORD_W-1:0] state_seed_ff;
   logic [twsp_pkg::WORD_W-1:0] stream_seed_ff;
   logic                        csr_write;
   logic                        push_valid;
   logic                        push_stall;
   twsp_pkg::entry_type         push_entry;
   logic                        pop_valid;
   logic                        pop_stall;
   twsp_pkg::entry_type         pop_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = paddr[3] ? stream_seed_ff : state_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_seed_ff  <= '0;
         stream_seed_ff <= '0;
      end else if (csr_write) begin
         if (paddr[3]) begin
            stream_seed_ff <= pwdata;
         end else begin
            state_seed_ff <= pwdata;
         end
      end
   end

   twsp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .state_seed     (state_seed_ff),
      .stream_seed    (stream_seed_ff),
      .push_valid     (push_valid),
      .push_stall     (push_stall),
      .push_entry     (push_entry)
   );

   twsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_entry  (pop_entry)
   );

   twsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_stall       (pop_stall),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule

@@ hw/rtl/twsp_front.sv @@
`timescale 1ns / 1ps

module twsp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [twsp_pkg::OP_W-1:0]           req_operation,
   input  logic [twsp_pkg::WORD_W-1:0]         req_low_bound,
   input  logic [twsp_pkg::WORD_W-1:0]         req_high_bound,
   input  logic [twsp_pkg::WORD_W-1:0]         state_seed,
   input  logic [twsp_pkg::WORD_W-1:0]         stream_seed,
   output logic                                push_valid,
   input  logic                                push_stall,
   output twsp_pkg::entry_type                 push_entry
);

   logic [twsp_pkg::WORD_W-1:0] state_ff;
   logic [twsp_pkg::WORD_W-1:0] state_in;
   logic [twsp_pkg::WORD_W-1:0] stream_ff;
   logic [twsp_pkg::WORD_W-1:0] stream_in;
   logic [twsp_pkg::WORD_W-1:0] mix_stream;
   logic [twsp_pkg::WORD_W-1:0] mix_state;
   logic [twsp_pkg::WORD_W-1:0] mix_final;
   logic                        accept;

   assign req_stall  = push_stall;
   assign push_valid = req_valid;
   assign accept     = req_valid && !push_stall;

   assign mix_stream = stream_ff ^ state_ff;
   assign mix_state  = state_ff ^ mix_stream;
   assign mix_final  = {mix_state[18:0], mix_state[63:19]};

   always_comb begin
      state_in             = state_ff;
      stream_in            = stream_ff;
      push_entry.times5    = state_ff + {state_ff[61:0], 2'b00};
      push_entry.low_bound = req_low_bound;
      push_entry.high_bound = req_high_bound;
      push_entry.kind      = twsp_pkg::KIND_ZERO;
      unique case (req_operation)
         twsp_pkg::OP_RAW, twsp_pkg::OP_URANGE, twsp_pkg::OP_SRANGE: begin
            state_in  = mix_final;
            stream_in = mix_stream ^ {stream_ff[46:0], 17'd0};
            if (req_operation == twsp_pkg::OP_RAW) begin
               push_entry.kind = twsp_pkg::KIND_RAW;
            end else if (req_operation == twsp_pkg::OP_URANGE) begin
               push_entry.kind = twsp_pkg::KIND_URANGE;
            end else begin
               push_entry.kind = twsp_pkg::KIND_SRANGE;
            end
         end
         twsp_pkg::OP_SEED: begin
            state_in  = state_seed;
            stream_in = stream_seed;
         end
         twsp_pkg::OP_RESEED: begin
            state_in = state_seed;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         stream_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         stream_ff <= stream_in;
      end
   end

endmodule

@@ hw/rtl/twsp_queue.sv @@
`timescale 1ns / 1ps

module twsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_stall,
   input  twsp_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_stall,
   output twsp_pkg::entry_type pop_entry
);

   twsp_pkg::entry_type                slot_ff [twsp_pkg::QUEUE_DEPTH];
   logic [twsp_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [twsp_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [twsp_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [twsp_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [twsp_pkg::QCOUNT_W-1:0]      count_ff;
   logic [twsp_pkg::QCOUNT_W-1:0]      count_in;
   logic                               push;
   logic                               pop;

   assign push_stall = (count_ff == twsp_pkg::QCOUNT_W'(twsp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/twsp_back.sv @@
`timescale 1ns / 1ps

module twsp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_stall,
   input  twsp_pkg::entry_type         pop_entry,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [twsp_pkg::WORD_W-1:0] rsp_value,
   output logic                        rsp_range_error
);

   localparam int W = twsp_pkg::WORD_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MIX   = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIX   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [twsp_pkg::COUNT_W-1:0] LAST_STEP = twsp_pkg::COUNT_W'(W - 1);

   logic [2:0]                      state_ff;
   logic [2:0]                      state_in;
   logic [twsp_pkg::KIND_W-1:0]     kind_ff;
   logic [twsp_pkg::KIND_W-1:0]     kind_in;
   logic [W-1:0]                    times5_ff;
   logic [W-1:0]                    times5_in;
   logic [W-1:0]                    lo_ff;
   logic [W-1:0]                    lo_in;
   logic [W-1:0]                    hi_ff;
   logic [W-1:0]                    hi_in;
   logic [W-1:0]                    raw_ff;
   logic [W-1:0]                    raw_in;
   logic [W-1:0]                    span_ff;
   logic [W-1:0]                    span_in;
   logic [W-1:0]                    rem_ff;
   logic [W-1:0]                    rem_in;
   logic [W-1:0]                    div_ff;
   logic [W-1:0]                    div_in;
   logic [twsp_pkg::COUNT_W-1:0]    count_ff;
   logic [twsp_pkg::COUNT_W-1:0]    count_in;
   logic                            neg_ff;
   logic                            neg_in;
   logic [W-1:0]                    res_ff;
   logic [W-1:0]                    res_in;
   logic                            err_ff;
   logic                            err_in;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [W-1:0]                    out_value_ff;
   logic [W-1:0]                    out_value_in;
   logic                            out_err_ff;
   logic                            out_err_in;
   logic [W-1:0]                    rotated;
   logic [W:0]                      trial;
   logic [W:0]                      trial_diff;
   logic                            out_free;

   assign pop_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_range_error = out_err_ff;

   assign rotated    = {times5_ff[W-8:0], times5_ff[W-1:W-7]};
   assign trial      = {rem_ff, div_ff[W-1]};
   assign trial_diff = trial - {1'b0, span_ff};
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      times5_in    = times5_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      raw_in       = raw_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               kind_in   = pop_entry.kind;
               times5_in = pop_entry.times5;
               lo_in     = pop_entry.low_bound;
               hi_in     = pop_entry.high_bound;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            raw_in   = rotated + {rotated[W-4:0], 3'b000};
            span_in  = hi_ff - lo_ff + W'(1);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            err_in   = 1'b0;
            rem_in   = '0;
            count_in = '0;
            neg_in   = 1'b0;
            div_in   = raw_ff;
            state_in = ST_DONE;
            unique case (kind_ff)
               twsp_pkg::KIND_RAW: begin
                  res_in = raw_ff;
               end
               twsp_pkg::KIND_URANGE: begin
                  if (span_ff == '0) begin
                     res_in = raw_ff + lo_ff;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
               twsp_pkg::KIND_SRANGE: begin
                  if (span_ff == '0 || span_ff[W-1]) begin
                     err_in = 1'b1;
                     res_in = raw_ff;
                  end else begin
                     neg_in   = raw_ff[W-1];
                     div_in   = raw_ff[W-1] ? W'(0) - raw_ff : raw_ff;
                     state_in = ST_DIV;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ST_DIV: begin
            if (!trial_diff[W]) begin
               rem_in = trial_diff[W-1:0];
            end else begin
               rem_in = trial[W-1:0];
            end
            div_in   = {div_ff[W-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            res_in   = neg_ff ? lo_ff - rem_ff : lo_ff + rem_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = res_ff;
               out_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      times5_ff    <= times5_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      raw_ff       <= raw_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      count_ff     <= count_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTH
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < span_ff)
      else $error("remainder not below span during division");

   a_div_ends_in_fix: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && count_ff == LAST_STEP |=> state_ff == ST_FIX)
      else $error("division did not end after the last step");

   a_fix_then_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |=> state_ff == ST_DONE)
      else $error("fix-up step not followed by hand-off");

   a_handoff_loads_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> out_valid_ff && state_ff == ST_IDLE)
      else $error("finished word not moved to the output register");
`endif

endmodule
